>>> hw/rtl/sw_pkg.sv
// Shared types and constants for the debounced-button stopwatch.
package sw_pkg;

  localparam int unsigned DEB_W    = 8;
  localparam int unsigned MS_W     = 17;
  localparam int unsigned PHASE_W  = 10;
  localparam int unsigned CFG_W    = 17;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [DEB_W-1:0]   DEBOUNCE_RESET = 8'd50;
  localparam logic [MS_W-1:0]    WRAP_RESET     = 17'd120000;
  localparam logic [DEB_W-1:0]   COUNT_MAX      = 8'd255;
  localparam logic [PHASE_W-1:0] MS_LAST        = 10'd999;
  localparam logic [PHASE_W-1:0] COLON_LIMIT    = 10'd501;
  localparam logic [5:0]         SEC_LAST       = 6'd59;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 1'b0,
    REG_WRAP     = 1'b1
  } cfg_reg_t;

  // Per-item control into the elapsed-time counter
  typedef struct packed {
    logic en;       // item accepted this cycle
    logic clear;    // debounced reset is high
    logic advance;  // running after this item's toggle
  } sw_timer_ctrl_t;

endpackage

>>> hw/rtl/stopwatch_with_debounced_buttons.sv
// Top level of the stopwatch: debouncers, run/pause control, colon phase, output register.
// Takes one item per millisecond tick and returns one result item per input item,
// with a throughput of one item per clock cycle and the result registered in the
// cycle after the item is taken: the whole update runs between the state registers
// and the output register, and a new item is taken whenever the output register is empty or being drained.
// tdata in: bit 0 start/stop level, bit 1 reset level. Configuration writes
// (index 0 debounce ticks, index 1 wrap limit in ms) take effect on the next item.
module stopwatch_with_debounced_buttons
  import sw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [0] start_stop_raw, [1] reset_raw
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,   // [1:0] minutes, [7:2] seconds, [8] colon_on, [9] running
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [DEB_W-1:0]   debounce_ms;
  logic [MS_W-1:0]    wrap_ms;
  logic               accept;
  logic               paused;
  logic               paused_next;
  logic [PHASE_W-1:0] phase;
  logic               ss_level;
  logic               ss_level_next;
  logic               rs_level;
  logic               rs_level_next;
  logic [1:0]         minutes_next;
  logic [5:0]         seconds_next;
  sw_timer_ctrl_t     tctrl;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RESET;
      wrap_ms     <= WRAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_DEBOUNCE: debounce_ms <= cfg_data[DEB_W-1:0];
        REG_WRAP:     wrap_ms     <= cfg_data[MS_W-1:0];
        default:      ;
      endcase
    end
  end

  sw_debounce u_ss_deb (
    .clk         (clk),
    .rst         (rst),
    .en          (accept),
    .raw         (s_tdata[0]),
    .debounce_ms (debounce_ms),
    .level       (ss_level),
    .level_next  (ss_level_next)
  );

  sw_debounce u_rs_deb (
    .clk         (clk),
    .rst         (rst),
    .en          (accept),
    .raw         (s_tdata[1]),
    .debounce_ms (debounce_ms),
    .level       (rs_level),
    .level_next  (rs_level_next)
  );

  // reset button wins over a toggle on the same tick
  always_comb begin
    paused_next = paused;
    if (rs_level_next) begin
      paused_next = 1'b0;
    end else if (!ss_level && ss_level_next) begin
      paused_next = !paused;
    end
    tctrl.en      = accept;
    tctrl.clear   = rs_level_next;
    tctrl.advance = !paused_next;
  end

  sw_timer u_timer (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (tctrl),
    .wrap_ms      (wrap_ms),
    .minutes_next (minutes_next),
    .seconds_next (seconds_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      paused <= 1'b0;
      phase  <= '0;
    end else if (accept) begin
      paused <= paused_next;
      phase  <= (phase >= MS_LAST) ? '0 : phase + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {6'd0, !paused_next, (phase < COLON_LIMIT), seconds_next, minutes_next};
    end
  end

`ifndef SYNTHESIS
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && !m_tready) |-> !s_tready)
    else $error("item taken while result stalled");
  a_phase_range: assert property (@(posedge clk) disable iff (rst) phase <= MS_LAST)
    else $error("colon phase out of range");
  a_reset_runs: assert property (@(posedge clk) disable iff (rst)
      (accept && rs_level_next) |=> (!paused && m_tdata[9]))
    else $error("reset button did not resume running");
`endif

endmodule

>>> hw/rtl/sw_debounce.sv
// Debounce filter for one button, updated once per accepted item.
module sw_debounce
  import sw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             raw,
  input  logic [DEB_W-1:0] debounce_ms,
  output logic             level,
  output logic             level_next
);

  logic             last;
  logic             last_next;
  logic [DEB_W-1:0] count;
  logic [DEB_W-1:0] count_next;

  always_comb begin
    if (raw != last) begin
      last_next  = raw;
      count_next = '0;
    end else begin
      last_next  = last;
      count_next = (count < COUNT_MAX) ? count + 1'b1 : count;
    end
    level_next = (count_next >= debounce_ms) ? last_next : level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last  <= 1'b0;
      count <= '0;
      level <= 1'b0;
    end else if (en) begin
      last  <= last_next;
      count <= count_next;
      level <= level_next;
    end
  end

endmodule

>>> hw/rtl/sw_timer.sv
// Elapsed-time counter kept both as a raw ms count and as min/sec/ms digits.
module sw_timer
  import sw_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  sw_timer_ctrl_t ctrl,
  input  logic [MS_W-1:0] wrap_ms,
  output logic [1:0]     minutes_next,
  output logic [5:0]     seconds_next
);

  logic [MS_W-1:0]    elapsed;
  logic [MS_W-1:0]    elapsed_next;
  logic [PHASE_W-1:0] ms_cnt;
  logic [PHASE_W-1:0] ms_cnt_next;
  logic [5:0]         sec_cnt;
  logic [1:0]         min_cnt;
  logic [MS_W:0]      elapsed_inc;

  assign elapsed_inc = {1'b0, elapsed} + 1'b1;

  always_comb begin
    elapsed_next = elapsed;
    ms_cnt_next  = ms_cnt;
    seconds_next = sec_cnt;
    minutes_next = min_cnt;
    if (ctrl.clear || (ctrl.advance && (elapsed_inc > {1'b0, wrap_ms}))) begin
      elapsed_next = '0;
      ms_cnt_next  = '0;
      seconds_next = '0;
      minutes_next = '0;
    end else if (ctrl.advance) begin
      elapsed_next = elapsed_inc[MS_W-1:0];
      if (ms_cnt == MS_LAST) begin
        ms_cnt_next = '0;
        if (sec_cnt == SEC_LAST) begin
          seconds_next = '0;
          minutes_next = min_cnt + 1'b1;
        end else begin
          seconds_next = sec_cnt + 1'b1;
        end
      end else begin
        ms_cnt_next = ms_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
      ms_cnt  <= '0;
      sec_cnt <= '0;
      min_cnt <= '0;
    end else if (ctrl.en) begin
      elapsed <= elapsed_next;
      ms_cnt  <= ms_cnt_next;
      sec_cnt <= seconds_next;
      min_cnt <= minutes_next;
    end
  end

`ifndef SYNTHESIS
  a_ms_range: assert property (@(posedge clk) disable iff (rst) ms_cnt <= MS_LAST)
    else $error("ms digit out of range");
  a_sec_range: assert property (@(posedge clk) disable iff (rst) sec_cnt <= SEC_LAST)
    else $error("seconds digit out of range");
  a_digits_match: assert property (@(posedge clk) disable iff (rst)
      ({20'd0, min_cnt} * 22'd60000 + {16'd0, sec_cnt} * 22'd1000 + {12'd0, ms_cnt})
      == {5'd0, elapsed})
    else $error("digits disagree with elapsed count");
`endif

endmodule
